// ===== rtl/core/xorshift32_range_generator_macros.svh =====
// ----------------------------------------------------------------------------
// xorshift32 range generator: assertion macros
// Shared concurrent assertion forms for the block's checker.
// ----------------------------------------------------------------------------
`ifndef XORSHIFT32_RANGE_GENERATOR_MACROS_SVH
`define XORSHIFT32_RANGE_GENERATOR_MACROS_SVH

// Implication checked only while out of reset.
`define XRG_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked at every edge, reset included.
`define XRG_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/xrg_pkg.sv =====
// ----------------------------------------------------------------------------
// xorshift32 range generator package
// Shared types, constants and the generator step function.
// ----------------------------------------------------------------------------
`default_nettype none

package xrg_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W  = 5;

    localparam int unsigned XS_SHIFT_A = 13;
    localparam int unsigned XS_SHIFT_B = 17;
    localparam int unsigned XS_SHIFT_C = 5;

    localparam logic [WORD_W-1:0] SEED_RESET = 32'd1;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    // Control from the top level to the remainder unit
    typedef struct packed {
        logic  start;
        word_t dividend;
        word_t divisor;
    } div_ctrl_t;

    // Status from the remainder unit
    typedef struct packed {
        logic  done;
        word_t remainder;
    } div_stat_t;

    function automatic word_t xs_advance(input word_t x_in);
        word_t x;
        x = x_in;
        x = x ^ (x << XS_SHIFT_A);
        x = x ^ (x >> XS_SHIFT_B);
        x = x ^ (x << XS_SHIFT_C);
        return x;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/xorshift32_range_generator.sv =====
// ----------------------------------------------------------------------------
// xorshift32 range generator
// Draws one xorshift32 word per request and folds it into [lower, upper).
// ----------------------------------------------------------------------------
// Each request runs these steps from acceptance to a result in the output
// register: the acceptance edge steps the generator and loads the remainder
// unit, then the bit-serial remainder unit runs (one quotient bit per
// cycle), the lower bound is added into a register, and ST_DONE moves the
// result into the output register. The next request is taken once the block
// is back in ST_IDLE, so a request never starts before the last has left
// ST_DONE. An empty range (upper equal to lower) skips the remainder unit: the
// result goes via ST_DONE to the output, the generator still advances, and
// lower comes back with m_tuser set. The block takes one request at a time;
// the output register lets the next request start while a result waits, and
// a finished result holds until that register is free. The seed write port
// is taken only while the block is idle with the output register empty, and
// reloads the generator word at once; requests hold off while a seed write
// is offered.
`default_nettype none

module xorshift32_range_generator (
    input  wire                 aclk,
    input  wire                 aresetn,
    // request channel
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire  [63:0]         s_tdata,   // [31:0] lower_bound, [63:32] upper_bound
    // result channel
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [31:0]         m_tdata,   // [31:0] value
    output logic                m_tuser,   // [0] range_error
    // seed write channel
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire  [31:0]         cfg_data   // [31:0] seed
);
    import xrg_pkg::*;

    state_t     state_reg, state_next;
    word_t      gen_reg,   gen_next;
    word_t      lower_reg, lower_next;
    word_t      res_reg,   res_next;
    logic       err_reg,   err_next;

    logic       m_valid_reg, m_valid_next;
    word_t      m_data_reg,  m_data_next;
    logic       m_err_reg,   m_err_next;

    div_ctrl_t  div_ctrl;
    div_stat_t  div_stat;

    logic       s_acc;
    logic       cfg_acc;
    word_t      req_lower;
    word_t      req_upper;
    word_t      req_span;
    word_t      new_word;

    assign req_lower = s_tdata[31:0];
    assign req_upper = s_tdata[63:32];
    assign req_span  = req_upper - req_lower;
    assign new_word  = xs_advance(gen_reg);

    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_acc   = cfg_valid && cfg_ready;

    xrg_rem_unit u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (div_ctrl),
        .stat    (div_stat)
    );

    always_comb begin
        state_next   = state_reg;
        gen_next     = gen_reg;
        lower_next   = lower_reg;
        res_next     = res_reg;
        err_next     = err_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_err_next   = m_err_reg;

        div_ctrl.start    = 1'b0;
        div_ctrl.dividend = new_word;
        div_ctrl.divisor  = req_span;

        // drop the held result once the consumer takes it
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    gen_next   = new_word;
                    lower_next = req_lower;
                    if (req_span == '0) begin
                        // empty range: no reduction, flag it
                        res_next   = req_lower;
                        err_next   = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        err_next       = 1'b0;
                        div_ctrl.start = 1'b1;
                        state_next     = ST_DIV;
                    end
                end
                // reload the generator on a seed write; requests hold off meanwhile
                if (cfg_acc) begin
                    gen_next = cfg_data;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    res_next   = div_stat.remainder + lower_reg;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    m_err_next   = err_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            gen_reg     <= SEED_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            gen_reg     <= gen_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lower_reg  <= lower_next;
        res_reg    <= res_next;
        err_reg    <= err_next;
        m_data_reg <= m_data_next;
        m_err_reg  <= m_err_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_err_reg;

endmodule

`default_nettype wire

// ===== rtl/core/xrg_rem_unit.sv =====
// ----------------------------------------------------------------------------
// xorshift32 range generator: remainder unit
// Restoring division, one quotient bit per cycle; keeps the remainder only.
// ----------------------------------------------------------------------------
`default_nettype none

module xrg_rem_unit (
    input  wire               aclk,
    input  wire               aresetn,
    input  xrg_pkg::div_ctrl_t ctrl,
    output xrg_pkg::div_stat_t stat
);
    import xrg_pkg::*;

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    word_t             quot_reg,  quot_next;
    word_t             dvsr_reg,  dvsr_next;
    word_t             rem_reg,   rem_next;

    logic [WORD_W:0]   rem_shift;
    logic [WORD_W:0]   rem_diff;

    always_comb begin
        rem_shift = {rem_reg, quot_reg[WORD_W-1]};
        rem_diff  = rem_shift - {1'b0, dvsr_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        dvsr_next = dvsr_reg;
        rem_next  = rem_reg;

        if (ctrl.start) begin
            busy_next = 1'b1;
            cnt_next  = '1;
            quot_next = ctrl.dividend;
            dvsr_next = ctrl.divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            // shift in the next dividend bit, subtract when it fits
            quot_next = {quot_reg[WORD_W-2:0], 1'b0};
            if (!rem_diff[WORD_W]) begin
                rem_next = rem_diff[WORD_W-1:0];
            end else begin
                rem_next = rem_shift[WORD_W-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        dvsr_reg <= dvsr_next;
        rem_reg  <= rem_next;
    end

    assign stat.done      = done_reg;
    assign stat.remainder = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/core/xrg_checker.sv =====
// ----------------------------------------------------------------------------
// xorshift32 range generator: port checker
// Watches the top level's ports and flags sequencing slips.
// ----------------------------------------------------------------------------
`default_nettype none
`include "xorshift32_range_generator_macros.svh"

module xrg_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [31:0] m_tdata,
    input wire        m_tuser,
    input wire        cfg_ready
);

    // reset empties the output register
    `XRG_ASSERT_NEXT(a_reset_clears_out, aclk, !aresetn, !m_tvalid, "m_tvalid after reset")

    // a held result keeps its payload
    `XRG_ASSERT_IMPL(a_out_hold, aclk, aresetn, $past(m_tvalid && !m_tready) && $past(aresetn),
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // one request at a time: no new request right after one is taken
    `XRG_ASSERT_IMPL(a_one_req, aclk, aresetn, $past(s_tvalid && s_tready) && $past(aresetn),
        !s_tready, "request taken while busy")

    // no seed write while a request is in flight
    `XRG_ASSERT_IMPL(a_cfg_idle, aclk, aresetn, $past(s_tvalid && s_tready) && $past(aresetn),
        !cfg_ready, "seed write open while busy")

endmodule

bind xorshift32_range_generator xrg_checker u_xrg_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xorshift32 range generator testbench
// Drives bounded draw requests and seed writes into the generator, predicts
// every draw from its own copy of the generator word and compares each result
// field by field, with bursty requests and a stalling result receiver.
// ----------------------------------------------------------------------------

module tb_top;

    import xrg_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 100;

    typedef struct packed {
        word_t value;
        logic  range_error;
    } draw_t;

    // Tracks the generator word and the draws still owed by the block.
    class draw_scoreboard;
        word_t       gen_word;
        draw_t       owed_draws[$];
        int unsigned fail_count;

        function new();
            gen_word   = SEED_RESET;
            fail_count = 0;
        endfunction

        function void reload(word_t seed_value);
            gen_word = seed_value;
        endfunction

        function word_t next_word(word_t x);
            word_t w;
            w = x;
            w = w ^ (w << XS_SHIFT_A);
            w = w ^ (w >> XS_SHIFT_B);
            w = w ^ (w << XS_SHIFT_C);
            return w;
        endfunction

        function void note_request(word_t lower, word_t upper);
            word_t span;
            draw_t d;
            span     = upper - lower;
            gen_word = next_word(gen_word);
            if (span == '0) begin
                d.value       = lower;
                d.range_error = 1'b1;
            end else begin
                d.value       = (gen_word % span) + lower;
                d.range_error = 1'b0;
            end
            owed_draws = {owed_draws, d};
        endfunction

        function void check_draw(word_t value, logic range_error);
            draw_t d;
            if (owed_draws.size() == 0) begin
                $error("unexpected result: value %h range_error %b", value, range_error);
                fail_count++;
                return;
            end
            d = owed_draws.pop_front();
            if (value !== d.value) begin
                $error("value: expected %h, actual %h", d.value, value);
                fail_count++;
            end
            if (range_error !== d.range_error) begin
                $error("range_error: expected %b, actual %b", d.range_error, range_error);
                fail_count++;
            end
        endfunction

        function int pending();
            return owed_draws.size();
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;   // [31:0] lower_bound, [63:32] upper_bound
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // [31:0] value
    logic        m_tuser;          // [0] range_error
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;   // [31:0] seed

    draw_scoreboard board;
    int burst_left = 0;
    int stall_mode = 0;
    int mode_left  = 0;

    xorshift32_range_generator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result receiver: check accepted results, stall in modes of random length.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_draw(m_tdata, m_tuser);
        end
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(20, 300);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= (mode_left % 37 == 0);
        endcase
    end

    task automatic send_request(input word_t lower, input word_t upper);
        s_tdata  <= {upper, lower};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        board.note_request(lower, upper);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 45)) @(posedge aclk);
            end else begin
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end else begin
            burst_left--;
        end
    endtask

    // Drop valid and hold until every owed draw has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (board.pending() != 0);
        burst_left = 0;
    endtask

    task automatic write_seed(input word_t seed_value);
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_data  <= seed_value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.reload(seed_value);
    endtask

    task automatic random_request();
        word_t lower;
        word_t upper;
        int    kind;
        lower = $urandom;
        kind  = $urandom_range(0, 9);
        case (kind)
            4, 5:    upper = lower + $urandom_range(1, 1000);
            6:       upper = lower;
            7:       upper = lower - $urandom_range(1, 1 << 20);
            8:       upper = lower + (32'd1 << $urandom_range(0, 31));
            9: begin
                lower = 32'hFFFF_FFFF - $urandom_range(0, 255);
                upper = $urandom_range(0, 255);
            end
            default: upper = $urandom;
        endcase
        send_request(lower, upper);
    endtask

    initial begin
        board = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset seed: bound extremes, empty ranges, wrapped spans.
        send_request(32'h0000_0000, 32'h0000_0000);
        send_request(32'h0000_0000, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'h0000_0000);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'h0000_0005, 32'h0000_0003);
        send_request(32'h0000_0001, 32'h0000_0000);
        send_request(32'h0000_0000, 32'h0000_0001);
        send_request(32'h8000_0000, 32'h0000_0000);
        send_request(32'h0000_0000, 32'h8000_0000);
        send_request(32'h1234_5678, 32'h1234_5679);
        send_request(32'h0000_0064, 32'h0000_00C8);
        send_request(32'hAAAA_AAAA, 32'h5555_5555);

        // Zero seed: generator sticks at zero.
        write_seed(32'h0000_0000);
        send_request(32'h0000_0000, 32'hFFFF_FFFF);
        send_request(32'hDEAD_BEEF, 32'h0000_0010);
        send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'h0000_0000);

        write_seed(32'hFFFF_FFFF);
        send_request(32'h0000_0000, 32'hFFFF_FFFF);
        send_request(32'h0000_0000, 32'h0000_0007);
        send_request(32'h5555_5555, 32'hAAAA_AAAA);
        send_request(32'h0000_0003, 32'h0000_0003);

        // Random phases, each after a fresh seed write.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                1:       write_seed(32'h8000_0000);
                3:       write_seed(32'h0000_0001);
                default: write_seed($urandom);
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 2 && n == PHASE_ITEMS / 2) begin
                    drain_results();
                end
                random_request();
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.fail_count == 0 && board.pending() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/xrg_pkg.sv
rtl/core/xrg_rem_unit.sv
rtl/core/xorshift32_range_generator.sv
rtl/core/xrg_checker.sv
tb/sv/tb_top.sv
